[rtl/ddgtg_pkg.sv]
// Shared constants, register indexes and the CORDIC angle table of the go-to-goal controller.
package ddgtg_pkg;

	// Datapath widths.
	localparam int DX_W    = 33;  // target minus position
	localparam int XW      = 44;  // CORDIC x and y
	localparam int ZW      = 32;  // CORDIC angle, Q8.24
	localparam int DIST_W  = 34;  // distance, Q18.16
	localparam int ERR_W   = 21;  // heading error before wrapping
	localparam int NUM_W   = 55;  // magnitude of a rate numerator
	localparam int DEN_W   = 32;  // time step in microseconds
	localparam int RATE_W  = 42;  // saturated rate
	localparam int ACC_W   = 60;  // PD accumulators

	// Angle and scale constants.
	localparam logic signed [ZW-1:0]    PI_Q24       = 32'sd52707179;
	localparam logic signed [ERR_W-1:0] PI_Q12       = 21'sd12868;
	localparam logic signed [ERR_W-1:0] TWO_PI_Q12   = 21'sd25736;
	localparam logic [29:0]             INV_GAIN_Q30 = 30'd652032874;
	localparam logic [19:0]             USEC_PER_SEC = 20'd1000000;
	localparam logic [NUM_W-1:0]        DERIV_SAT    = 55'd1099511627776;

	// Configuration register indexes.
	localparam logic [2:0] REG_GAIN_P_DIST = 3'd0;
	localparam logic [2:0] REG_GAIN_D_DIST = 3'd1;
	localparam logic [2:0] REG_GAIN_P_HEAD = 3'd2;
	localparam logic [2:0] REG_GAIN_D_HEAD = 3'd3;
	localparam logic [2:0] REG_STOP_RADIUS = 3'd4;
	localparam logic [2:0] REG_WHEEL_LIMIT = 3'd5;
	localparam logic [2:0] REG_DEFAULT_DT  = 3'd6;

	localparam logic signed [ZW-1:0] ATAN_SMALL [0:7] = '{
		32'sd13176795, 32'sd7778716, 32'sd4110060, 32'sd2086331,
		32'sd1047214, 32'sd524117, 32'sd262123, 32'sd131069
	};

	// Elementary rotation angle for CORDIC round i, Q8.24.
	function automatic logic signed [ZW-1:0] atan_step(input logic [5:0] i);
		logic [5:0] sh;
		sh = 6'd24 - i;
		if (i < 6'd8)
			return ATAN_SMALL[i[2:0]];
		else if (i <= 6'd24)
			return ZW'(33'd1 << sh);
		else
			return '0;
	endfunction

endpackage

[rtl/ddgtg_cordic.sv]
// Iterative CORDIC vectoring unit: one rotation per cycle through a shared shifter.
module ddgtg_cordic import ddgtg_pkg::*; #(
	parameter int ITER = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DX_W-1:0]  dx,
	input  logic signed [DX_W-1:0]  dy,
	output logic                    done,
	output logic [XW-1:0]           mag,
	output logic signed [ZW-1:0]    angle
);
	localparam int CW = $clog2(ITER + 1);

	logic signed [XW-1:0] x_q, y_q, xs0, ys0, x_sh, y_sh;
	logic signed [ZW-1:0] z_q, step;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;

	// Scale the difference by 256 before rotating.
	assign xs0  = {{(XW-DX_W-8){dx[DX_W-1]}}, dx, 8'd0};
	assign ys0  = {{(XW-DX_W-8){dy[DX_W-1]}}, dy, 8'd0};
	assign x_sh = x_q >>> cnt_q;
	assign y_sh = y_q >>> cnt_q;
	assign step = atan_step(6'(cnt_q));

	// Start folds the left half plane over, then one rotation per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				if (dx < 0) begin
					x_q <= -xs0;
					y_q <= -ys0;
					z_q <= (dy >= 0) ? PI_Q24 : -PI_Q24;
				end else begin
					x_q <= xs0;
					y_q <= ys0;
					z_q <= '0;
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + step;
				end else begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - step;
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign mag   = x_q;
	assign angle = z_q;
endmodule

[rtl/ddgtg_div.sv]
// Restoring divider: one quotient bit per cycle.
module ddgtg_div import ddgtg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [NUM_W-1:0]  quo
);
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [5:0]       cnt_q;
	logic             busy_q, done_q;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// The numerator shifts out at the top while quotient bits enter below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[rtl/diff_drive_pd_go_to_goal.sv]
// Top level of the PD go-to-goal controller for a differential-drive robot.
// Each input transaction carries the pose, a microsecond time stamp and a target point, and
// yields one output transaction with the left and right wheel speeds (Q6.16, saturated to
// wheel_limit) and a stopped flag. When the robot is moving, the serial divider works out
// each of the two rates in turn after the CORDIC and the distance scaling, and the heading
// wrap takes at most two 2*pi steps; the divider is skipped when the time step is not
// positive, and the heading wrap, rates and gains are skipped inside the stop radius. The
// input becomes ready again as the result is registered. The input is not ready while an
// item is at work; a finished result waits in the output register. Configuration may be
// written only while the block is idle.
module diff_drive_pd_go_to_goal import ddgtg_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x[31:0], pos_y[63:32], heading[79:64], time_us[111:80],
	// target_x[143:112], target_y[175:144]
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// speed_left[21:0], speed_right[43:22], zero fill [47:44]
	output logic [47:0]  m_tdata,
	// stopped[0]
	output logic         m_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_CSTART, S_CORD, S_DMUL, S_DCHK, S_WRAP, S_RNUM, S_RSTART, S_RWAIT,
		S_MAC, S_SUM, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] gpd_q, gdd_q, gph_q, gdh_q;
	logic [23:0] stop_radius_q;
	logic [20:0] wheel_limit_q;
	logic [19:0] default_dt_q;

	// Controller state.
	logic signed [15:0]    prev_err_q;
	logic [DIST_W-1:0]     prev_dist_q;
	logic [31:0]           prev_time_q;

	// Item registers.
	logic signed [DX_W-1:0]   dx_q, dy_q;
	logic signed [15:0]       heading_q;
	logic [31:0]              time_q;
	logic [35:0]              xm_q;
	logic [65:0]              dacc_q;
	logic [DIST_W-1:0]        dist_q;
	logic [DEN_W-1:0]         dt_q;
	logic                     dt_ok_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [55:0]       num_q;
	logic                     sel_q;
	logic signed [RATE_W-1:0] rd_q, rh_q;
	logic signed [58:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_lin_q, acc_ang_q;
	logic [2:0]               k_q;
	logic signed [21:0]       res_left_q, res_right_q;
	logic                     res_stop_q;
	logic                     m_tvalid_q, m_tuser_q;
	logic [43:0]              m_data_q;

	// CORDIC and divider connections.
	logic                     cord_start, cord_done, div_start, div_done;
	logic [XW-1:0]            cord_mag;
	logic signed [ZW-1:0]     cord_angle;
	logic [NUM_W-1:0]         div_num, div_quo, quo_sat;
	logic signed [RATE_W-1:0] rate_w;

	// Combinational helpers.
	logic signed [ERR_W-1:0]  z_round;
	logic [47:0]              dmul;
	logic [DIST_W-1:0]        dist_w;
	logic signed [32:0]       dt_w;
	logic signed [35:0]       delta_w;
	logic signed [16:0]       mul_a;
	logic signed [RATE_W-1:0] mul_b;
	logic signed [ACC_W-1:0]  lin_w, ang_w, left_w, right_w, lim_w;
	logic signed [21:0]       left_c, right_c;

	ddgtg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .dx(dx_q), .dy(dy_q),
		.done(cord_done), .mag(cord_mag), .angle(cord_angle)
	);

	ddgtg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(dt_q),
		.done(div_done), .quo(div_quo)
	);

	assign s_tready   = (state_q == S_IDLE);
	assign cord_start = (state_q == S_CSTART);
	assign div_start  = (state_q == S_RSTART);
	assign div_num    = num_q[55] ? NUM_W'(-num_q) : NUM_W'(num_q);

	// Bearing rounded to Q4.12 minus the heading.
	assign z_round = ERR_W'((cord_angle + 32'sd2048) >>> 12) - ERR_W'(heading_q);

	// Distance scaling multiplies one 18-bit half of x per cycle.
	assign dmul   = (k_q[0] ? xm_q[35:18] : xm_q[17:0]) * INV_GAIN_Q30;
	assign dist_w = DIST_W'((dacc_q + 66'd536870912) >> 30);

	// Time step, with the default on the first sample.
	assign dt_w = (prev_time_q != 32'd0) ? ($signed({1'b0, time_q}) - $signed({1'b0, prev_time_q}))
		: $signed({13'd0, default_dt_q});

	// Difference to the stored value for the rate being worked on.
	assign delta_w = sel_q ? 36'(err_q - ERR_W'(prev_err_q))
		: $signed({2'b00, dist_q}) - $signed({2'b00, prev_dist_q});

	// Rate magnitude clamped, then signed.
	assign quo_sat = (div_quo > DERIV_SAT) ? DERIV_SAT : div_quo;
	assign rate_w  = num_q[55] ? -RATE_W'(quo_sat) : RATE_W'(quo_sat);

	// Operand selection for the shared gain multiplier.
	always_comb begin
		case (k_q[2:1])
			2'd0:    begin mul_a = {1'b0, gpd_q}; mul_b = RATE_W'(dist_q); end
			2'd1:    begin mul_a = {1'b0, gdd_q}; mul_b = rd_q; end
			2'd2:    begin mul_a = {1'b0, gph_q}; mul_b = RATE_W'(err_q); end
			default: begin mul_a = {1'b0, gdh_q}; mul_b = rh_q; end
		endcase
	end

	// Rounding, mixing and saturation.
	assign lin_w   = (acc_lin_q + 60'sd2048) >>> 12;
	assign ang_w   = (acc_ang_q + 60'sd128) >>> 8;
	assign left_w  = lin_w - ang_w;
	assign right_w = lin_w + ang_w;
	assign lim_w   = $signed({39'd0, wheel_limit_q});
	assign left_c  = (left_w > lim_w) ? 22'(lim_w) : (left_w < -lim_w) ? 22'(-lim_w)
		: left_w[21:0];
	assign right_c = (right_w > lim_w) ? 22'(lim_w) : (right_w < -lim_w) ? 22'(-lim_w)
		: right_w[21:0];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpd_q         <= 16'd4096;
			gdd_q         <= 16'd819;
			gph_q         <= 16'd410;
			gdh_q         <= 16'd41;
			stop_radius_q <= 24'd16384;
			wheel_limit_q <= 21'd131072;
			default_dt_q  <= 20'd50000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P_DIST: gpd_q         <= cfg_data[15:0];
				REG_GAIN_D_DIST: gdd_q         <= cfg_data[15:0];
				REG_GAIN_P_HEAD: gph_q         <= cfg_data[15:0];
				REG_GAIN_D_HEAD: gdh_q         <= cfg_data[15:0];
				REG_STOP_RADIUS: stop_radius_q <= cfg_data;
				REG_WHEEL_LIMIT: wheel_limit_q <= cfg_data[20:0];
				REG_DEFAULT_DT:  default_dt_q  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Sequencer, controller state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_err_q  <= '0;
			prev_dist_q <= '0;
			prev_time_q <= '0;
			m_tvalid_q  <= 1'b0;
			k_q         <= '0;
			sel_q       <= 1'b0;
		end else begin
			// The output state refills the register itself, so it is not cleared there.
			if (m_tvalid_q && m_tready && state_q != S_OUT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						dx_q      <= $signed({s_tdata[143], s_tdata[143:112]})
							- $signed({s_tdata[31], s_tdata[31:0]});
						dy_q      <= $signed({s_tdata[175], s_tdata[175:144]})
							- $signed({s_tdata[63], s_tdata[63:32]});
						heading_q <= s_tdata[79:64];
						time_q    <= s_tdata[111:80];
						state_q   <= S_CSTART;
					end
				end
				S_CSTART: state_q <= S_CORD;
				S_CORD: begin
					if (cord_done) begin
						xm_q    <= cord_mag[43:8];
						err_q   <= z_round;
						dacc_q  <= '0;
						k_q     <= '0;
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					if (k_q[0]) begin
						dacc_q  <= dacc_q + {dmul, 18'd0};
						state_q <= S_DCHK;
					end else begin
						dacc_q <= 66'(dmul);
					end
					k_q <= k_q + 1'b1;
				end
				S_DCHK: begin
					dt_q        <= dt_w[31:0];
					dt_ok_q     <= dt_w > 0;
					prev_time_q <= time_q;
					if (dist_w <= DIST_W'(stop_radius_q)) begin
						prev_err_q  <= '0;
						prev_dist_q <= '0;
						res_left_q  <= '0;
						res_right_q <= '0;
						res_stop_q  <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						dist_q  <= dist_w;
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (err_q > PI_Q12) begin
						err_q <= err_q - TWO_PI_Q12;
					end else if (err_q < -PI_Q12) begin
						err_q <= err_q + TWO_PI_Q12;
					end else begin
						sel_q   <= 1'b0;
						state_q <= S_RNUM;
					end
				end
				S_RNUM: begin
					num_q <= 56'(delta_w * $signed({1'b0, USEC_PER_SEC}));
					if (dt_ok_q) begin
						state_q <= S_RSTART;
					end else begin
						if (sel_q) rh_q <= '0; else rd_q <= '0;
						sel_q   <= 1'b1;
						k_q     <= '0;
						state_q <= sel_q ? S_MAC : S_RNUM;
					end
				end
				S_RSTART: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (div_done) begin
						if (sel_q) rh_q <= rate_w; else rd_q <= rate_w;
						sel_q   <= 1'b1;
						k_q     <= '0;
						state_q <= sel_q ? S_MAC : S_RNUM;
					end
				end
				S_MAC: begin
					if (!k_q[0]) begin
						prod_q <= mul_a * mul_b;
						if (k_q == 3'd0) begin
							acc_lin_q <= '0;
							acc_ang_q <= '0;
						end
					end else if (!k_q[2]) begin
						acc_lin_q <= acc_lin_q + ACC_W'(prod_q);
					end else begin
						acc_ang_q <= acc_ang_q + ACC_W'(prod_q);
					end
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7)
						state_q <= S_SUM;
				end
				S_SUM: begin
					res_left_q  <= left_c;
					res_right_q <= right_c;
					res_stop_q  <= 1'b0;
					prev_err_q  <= err_q[15:0];
					prev_dist_q <= dist_q;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= {res_right_q, res_left_q};
						m_tuser_q  <= res_stop_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, m_data_q};
	assign m_tuser  = m_tuser_q;

	// A stopped result carries zero speeds.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[43:0] == 44'd0)
		else $error("stopped result with nonzero speed");

	// A moving result keeps its left speed within the wheel limit.
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> $signed(m_tdata[21:0]) <= $signed({1'b0, wheel_limit_q})
		&& $signed(m_tdata[21:0]) >= -$signed({1'b0, wheel_limit_q}))
		else $error("left speed beyond limit");

	// An accepted item keeps the input closed on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready while an item is at work");
endmodule
